// ===== src/mi3_pkg.sv =====
// Shared types and constants for the 3x3 matrix inverse core.
`default_nettype none
package mi3_pkg;

  localparam int IO_BITS       = 32;
  localparam int ELEM_BITS_DEF = 32;
  localparam int FRAC_BITS_DEF = 16;
  localparam int N_ELEM        = 9;
  localparam int N_COL         = 3;

  // cofactor k = a[i0]*a[i1] - a[i2]*a[i3], row-major adjugate
  localparam logic [3:0] COF_IDX [N_ELEM][4] = '{
    '{4'd4, 4'd8, 4'd5, 4'd7},
    '{4'd7, 4'd2, 4'd8, 4'd1},
    '{4'd1, 4'd5, 4'd2, 4'd4},
    '{4'd5, 4'd6, 4'd3, 4'd8},
    '{4'd8, 4'd0, 4'd6, 4'd2},
    '{4'd2, 4'd3, 4'd0, 4'd5},
    '{4'd3, 4'd7, 4'd4, 4'd6},
    '{4'd6, 4'd1, 4'd7, 4'd0},
    '{4'd0, 4'd4, 4'd1, 4'd3}
  };

  typedef struct packed {
    logic signed [IO_BITS-1:0] a00;
    logic signed [IO_BITS-1:0] a01;
    logic signed [IO_BITS-1:0] a02;
    logic signed [IO_BITS-1:0] a10;
    logic signed [IO_BITS-1:0] a11;
    logic signed [IO_BITS-1:0] a12;
    logic signed [IO_BITS-1:0] a20;
    logic signed [IO_BITS-1:0] a21;
    logic signed [IO_BITS-1:0] a22;
  } mi3_in_t;

  typedef struct packed {
    logic signed [IO_BITS-1:0] inv00;
    logic signed [IO_BITS-1:0] inv01;
    logic signed [IO_BITS-1:0] inv02;
    logic signed [IO_BITS-1:0] inv10;
    logic signed [IO_BITS-1:0] inv11;
    logic signed [IO_BITS-1:0] inv12;
    logic signed [IO_BITS-1:0] inv20;
    logic signed [IO_BITS-1:0] inv21;
    logic signed [IO_BITS-1:0] inv22;
    logic signed [IO_BITS-1:0] det_value;
    logic                      singular;
    logic                      overflow;
  } mi3_out_t;

  typedef struct packed {
    logic [IO_BITS-1:0] det_value;
    logic               singular;
    logic               dneg;
    logic               det_ovf;
  } mi3_det_info_t;

endpackage
`default_nettype wire

// ===== src/mi3_in_if.sv =====
// Request channel carrying one input matrix.
`default_nettype none
interface mi3_in_if;
  import mi3_pkg::*;
  logic    valid;
  logic    ready;
  mi3_in_t payload;
  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface
`default_nettype wire

// ===== src/mi3_out_if.sv =====
// Result channel carrying one inverse matrix with flags.
`default_nettype none
interface mi3_out_if;
  import mi3_pkg::*;
  logic     valid;
  logic     ready;
  mi3_out_t payload;
  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface
`default_nettype wire

// ===== src/mi3_cof.sv =====
// Cofactor stage: eighteen element products, then nine exact differences.
`default_nettype none
module mi3_cof #(
  parameter int ELEM_BITS = mi3_pkg::ELEM_BITS_DEF
) (
  input  logic                      clk,
  input  logic                      en,
  input  logic signed [ELEM_BITS-1:0] a   [mi3_pkg::N_ELEM],
  output logic signed [2*ELEM_BITS:0] cof [mi3_pkg::N_ELEM],
  output logic signed [ELEM_BITS-1:0] col [mi3_pkg::N_COL]
);
  import mi3_pkg::*;

  localparam int PW = 2 * ELEM_BITS;

  logic signed [PW-1:0]        pa [N_ELEM];
  logic signed [PW-1:0]        pb [N_ELEM];
  logic signed [ELEM_BITS-1:0] col1 [N_COL];

  for (genvar k = 0; k < N_ELEM; k++) begin : g_cof
    always_ff @(posedge clk) begin
      if (en) begin
        pa[k]  <= a[COF_IDX[k][0]] * a[COF_IDX[k][1]];
        pb[k]  <= a[COF_IDX[k][2]] * a[COF_IDX[k][3]];
        cof[k] <= {pa[k][PW-1], pa[k]} - {pb[k][PW-1], pb[k]};
      end
    end
  end

  // first column rides along for the determinant
  for (genvar c = 0; c < N_COL; c++) begin : g_col
    always_ff @(posedge clk) begin
      if (en) begin
        col1[c] <= a[3*c];
        col[c]  <= col1[c];
      end
    end
  end

endmodule
`default_nettype wire

// ===== src/mi3_det.sv =====
// Determinant stage: split products, sum, then magnitudes and det output.
`default_nettype none
module mi3_det #(
  parameter int ELEM_BITS = mi3_pkg::ELEM_BITS_DEF,
  parameter int FRAC_BITS = mi3_pkg::FRAC_BITS_DEF
) (
  input  logic                          clk,
  input  logic                          en,
  input  logic signed [2*ELEM_BITS:0]   cof  [mi3_pkg::N_ELEM],
  input  logic signed [ELEM_BITS-1:0]   col  [mi3_pkg::N_COL],
  output logic        [2*ELEM_BITS:0]   cm   [mi3_pkg::N_ELEM],
  output logic                          cneg [mi3_pkg::N_ELEM],
  output logic        [3*ELEM_BITS+1:0] dm,
  output mi3_pkg::mi3_det_info_t        info
);
  import mi3_pkg::*;

  localparam int CW = 2 * ELEM_BITS + 1;
  localparam int DW = 3 * ELEM_BITS + 2;

  logic signed [CW-1:0] pl [N_COL];
  logic signed [CW-1:0] ph [N_COL];
  logic signed [CW-1:0] cof1 [N_ELEM];
  logic signed [CW-1:0] cof2 [N_ELEM];
  logic signed [DW-1:0] det_n, det_r;

  logic                 dneg_n;
  logic [DW-1:0]        dm_n, m, lim, vm;
  logic [ELEM_BITS-1:0] ve;
  logic                 dsat;

  // a * cof as low half (unsigned) plus high half (signed) partial products
  for (genvar c = 0; c < N_COL; c++) begin : g_part
    always_ff @(posedge clk) begin
      if (en) begin
        pl[c] <= col[c] * $signed({1'b0, cof[c][ELEM_BITS-1:0]});
        ph[c] <= col[c] * $signed(cof[c][CW-1:ELEM_BITS]);
      end
    end
  end

  always_comb begin
    det_n = '0;
    for (int c = 0; c < N_COL; c++) begin
      det_n = det_n + (DW'(ph[c]) <<< ELEM_BITS) + DW'(pl[c]);
    end
  end

  always_comb begin
    dneg_n = det_r[DW-1];
    dm_n   = dneg_n ? DW'(-det_r) : DW'(det_r);
    m      = dm_n >> (2 * FRAC_BITS);
    lim    = (DW'(1) << (ELEM_BITS - 1)) - (dneg_n ? DW'(0) : DW'(1));
    dsat   = m > lim;
    vm     = dsat ? lim : m;
    ve     = vm[ELEM_BITS-1:0];
    if (dneg_n) begin
      ve = -ve;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      cof1  <= cof;
      cof2  <= cof1;
      det_r <= det_n;
      dm             <= dm_n;
      info.det_value <= IO_BITS'(signed'(ve));
      info.singular  <= (det_r == '0);
      info.dneg      <= dneg_n;
      info.det_ovf   <= dsat;
    end
  end

  for (genvar k = 0; k < N_ELEM; k++) begin : g_mag
    always_ff @(posedge clk) begin
      if (en) begin
        cneg[k] <= cof2[k][CW-1];
        cm[k]   <= cof2[k][CW-1] ? CW'(-cof2[k]) : CW'(cof2[k]);
      end
    end
  end

endmodule
`default_nettype wire

// ===== src/mi3_div_lane.sv =====
// One divider lane: pipelined restoring division, one quotient bit per stage.
`default_nettype none
module mi3_div_lane #(
  parameter int ELEM_BITS = mi3_pkg::ELEM_BITS_DEF,
  parameter int FRAC_BITS = mi3_pkg::FRAC_BITS_DEF
) (
  input  logic                          clk,
  input  logic                          en,
  input  logic        [2*ELEM_BITS:0]   cm,
  input  logic        [3*ELEM_BITS+1:0] dm,
  input  logic                          neg_in,
  output logic        [ELEM_BITS-1:0]   quo,
  output logic                          quo_ovf,
  output logic                          neg
);
  localparam int CW = 2 * ELEM_BITS + 1;
  localparam int DW = 3 * ELEM_BITS + 2;
  localparam int NW = CW + 2 * FRAC_BITS;
  localparam int W  = ((NW > DW + ELEM_BITS) ? NW : (DW + ELEM_BITS)) + 1;

  logic [W-1:0]         r   [ELEM_BITS];
  logic [DW-1:0]        d   [ELEM_BITS];
  logic [ELEM_BITS-1:0] q   [ELEM_BITS+1];
  logic                 ovf [ELEM_BITS+1];
  logic                 ng  [ELEM_BITS+1];
  logic [W-1:0]         r0;

  assign r0 = W'(cm) << (2 * FRAC_BITS);

  // a quotient of 2^ELEM_BITS or more saturates regardless of its bits
  always_ff @(posedge clk) begin
    if (en) begin
      r[0]   <= r0;
      d[0]   <= dm;
      q[0]   <= '0;
      ovf[0] <= r0 >= (W'(dm) << ELEM_BITS);
      ng[0]  <= neg_in;
    end
  end

  for (genvar s = 0; s < ELEM_BITS; s++) begin : g_stage
    localparam int K = ELEM_BITS - 1 - s;
    logic [W-1:0] trial;
    logic         take;

    assign trial = r[s] - (W'(d[s]) << K);
    assign take  = !trial[W-1];

    always_ff @(posedge clk) begin
      if (en) begin
        q[s+1]   <= q[s] | (ELEM_BITS'(take) << K);
        ovf[s+1] <= ovf[s];
        ng[s+1]  <= ng[s];
      end
    end

    if (s < ELEM_BITS - 1) begin : g_rem
      always_ff @(posedge clk) begin
        if (en) begin
          r[s+1] <= take ? trial : r[s];
          d[s+1] <= d[s];
        end
      end
    end
  end

  assign quo     = q[ELEM_BITS];
  assign quo_ovf = ovf[ELEM_BITS];
  assign neg     = ng[ELEM_BITS];

endmodule
`default_nettype wire

// ===== src/matrix_inverse_3x3_core.sv =====
// 3x3 matrix inverse core: adjugate over determinant, nine divider lanes.
// Usage:
//   mat carries one request per matrix (a00..a22, signed fixed point); inv
//   returns one result per request in order: inverse elements, determinant,
//   singular and overflow flags. valid/ready on both sides.
// Pipeline: from request accept to inv.valid a matrix passes the input register,
//   products, cofactors, determinant partials, sum, magnitudes, then the
//   divider lanes (one per inverse element, ELEM_BITS+1 stages: an overflow
//   check, then one quotient bit per stage), the merge/saturation stage and
//   the output register.
// Throughput: one matrix per cycle unless inv stalls; lanes fully pipelined.
// Reset (rst, synchronous): clears all valid bits; in-flight requests are
//   dropped and inv.valid goes low on the next cycle.
// Stall: a result waiting on inv.ready is held in the output register; one
//   further result lands in a skid register, after which mat.ready drops and
//   the whole pipeline holds until the output drains.
`default_nettype none
module matrix_inverse_3x3_core #(
  parameter int ELEM_BITS = mi3_pkg::ELEM_BITS_DEF,
  parameter int FRAC_BITS = mi3_pkg::FRAC_BITS_DEF
) (
  input logic        clk,
  input logic        rst,
  mi3_in_if.sink     mat,
  mi3_out_if.source  inv
);
  import mi3_pkg::*;

  localparam int CW  = 2 * ELEM_BITS + 1;
  localparam int DW  = 3 * ELEM_BITS + 2;
  localparam int LAT = ELEM_BITS + 8;

  logic                        adv;
  logic [LAT-1:0]              vld;
  logic signed [ELEM_BITS-1:0] a_in [N_ELEM];
  logic signed [ELEM_BITS-1:0] a_r  [N_ELEM];
  logic signed [CW-1:0]        cof  [N_ELEM];
  logic signed [ELEM_BITS-1:0] col  [N_COL];
  logic [CW-1:0]               cm   [N_ELEM];
  logic                        cneg [N_ELEM];
  logic [DW-1:0]               dm;
  mi3_det_info_t               info;
  mi3_det_info_t               info_d [ELEM_BITS+1];
  logic [ELEM_BITS-1:0]        quo     [N_ELEM];
  logic                        quo_ovf [N_ELEM];
  logic                        qneg    [N_ELEM];
  logic [IO_BITS-1:0]          inv_v   [N_ELEM];
  logic                        any_sat;
  mi3_out_t                    merge_n, p_d, out_d, skid_d;
  logic                        out_v, skid_v;

  assign adv       = !skid_v;
  assign mat.ready = adv;

  assign a_in[0] = mat.payload.a00[ELEM_BITS-1:0];
  assign a_in[1] = mat.payload.a01[ELEM_BITS-1:0];
  assign a_in[2] = mat.payload.a02[ELEM_BITS-1:0];
  assign a_in[3] = mat.payload.a10[ELEM_BITS-1:0];
  assign a_in[4] = mat.payload.a11[ELEM_BITS-1:0];
  assign a_in[5] = mat.payload.a12[ELEM_BITS-1:0];
  assign a_in[6] = mat.payload.a20[ELEM_BITS-1:0];
  assign a_in[7] = mat.payload.a21[ELEM_BITS-1:0];
  assign a_in[8] = mat.payload.a22[ELEM_BITS-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (adv) begin
      vld <= {vld[LAT-2:0], mat.valid};
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      a_r <= a_in;
    end
  end

  mi3_cof #(.ELEM_BITS(ELEM_BITS)) u_cof (
    .clk (clk),
    .en  (adv),
    .a   (a_r),
    .cof (cof),
    .col (col)
  );

  mi3_det #(.ELEM_BITS(ELEM_BITS), .FRAC_BITS(FRAC_BITS)) u_det (
    .clk  (clk),
    .en   (adv),
    .cof  (cof),
    .col  (col),
    .cm   (cm),
    .cneg (cneg),
    .dm   (dm),
    .info (info)
  );

  for (genvar k = 0; k < N_ELEM; k++) begin : g_lane
    mi3_div_lane #(.ELEM_BITS(ELEM_BITS), .FRAC_BITS(FRAC_BITS)) u_lane (
      .clk     (clk),
      .en      (adv),
      .cm      (cm[k]),
      .dm      (dm),
      .neg_in  (cneg[k] ^ info.dneg),
      .quo     (quo[k]),
      .quo_ovf (quo_ovf[k]),
      .neg     (qneg[k])
    );
  end

  // determinant status follows the lanes
  always_ff @(posedge clk) begin
    if (adv) begin
      info_d[0] <= info;
      for (int i = 1; i <= ELEM_BITS; i++) begin
        info_d[i] <= info_d[i-1];
      end
    end
  end

  // merge: sign, saturate, singular override
  always_comb begin
    logic                 negk;
    logic                 satk;
    logic [ELEM_BITS-1:0] lim;
    logic [ELEM_BITS-1:0] v;
    any_sat = 1'b0;
    for (int k = 0; k < N_ELEM; k++) begin
      negk = qneg[k] && (quo_ovf[k] || (quo[k] != '0));
      lim  = (ELEM_BITS'(1) << (ELEM_BITS - 1)) - (negk ? ELEM_BITS'(0) : ELEM_BITS'(1));
      satk = quo_ovf[k] || (quo[k] > lim);
      v    = satk ? lim : quo[k];
      if (negk) begin
        v = -v;
      end
      any_sat  = any_sat | satk;
      inv_v[k] = info_d[ELEM_BITS].singular ? '0 : IO_BITS'(signed'(v));
    end
    merge_n.inv00     = inv_v[0];
    merge_n.inv01     = inv_v[1];
    merge_n.inv02     = inv_v[2];
    merge_n.inv10     = inv_v[3];
    merge_n.inv11     = inv_v[4];
    merge_n.inv12     = inv_v[5];
    merge_n.inv20     = inv_v[6];
    merge_n.inv21     = inv_v[7];
    merge_n.inv22     = inv_v[8];
    merge_n.det_value = info_d[ELEM_BITS].det_value;
    merge_n.singular  = info_d[ELEM_BITS].singular;
    merge_n.overflow  = !info_d[ELEM_BITS].singular &&
                        (any_sat || info_d[ELEM_BITS].det_ovf);
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      p_d <= merge_n;
    end
  end

  // output register with one skid entry
  always_ff @(posedge clk) begin
    if (rst) begin
      out_v  <= 1'b0;
      skid_v <= 1'b0;
    end else if (!out_v || inv.ready) begin
      if (skid_v) begin
        out_v  <= 1'b1;
        skid_v <= 1'b0;
      end else begin
        out_v <= vld[LAT-1];
      end
    end else if (vld[LAT-1] && adv) begin
      skid_v <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!out_v || inv.ready) begin
      out_d <= skid_v ? skid_d : p_d;
    end else if (adv) begin
      skid_d <= p_d;
    end
  end

  assign inv.valid   = out_v;
  assign inv.payload = out_d;

endmodule
`default_nettype wire

// ===== src/mi3_chk.sv =====
// Port-level checks for the matrix inverse core, bound to the top level.
`default_nettype none
module mi3_chk (
  input logic              clk,
  input logic              rst,
  input logic              mat_ready,
  input logic              inv_valid,
  input logic              inv_ready,
  input mi3_pkg::mi3_out_t inv_payload
);
  import mi3_pkg::*;

  a_hold: assert property (@(posedge clk) disable iff (rst)
    inv_valid && !inv_ready |=> inv_valid)
    else $error("result dropped while stalled");

  a_rst_quiet: assert property (@(posedge clk)
    rst |=> !inv_valid)
    else $error("result after reset");

  a_singular: assert property (@(posedge clk) disable iff (rst)
    inv_valid && inv_payload.singular |->
      inv_payload.det_value == '0 && !inv_payload.overflow &&
      inv_payload.inv00 == '0 && inv_payload.inv11 == '0 &&
      inv_payload.inv22 == '0)
    else $error("singular result not cleared");

  a_backpressure: assert property (@(posedge clk) disable iff (rst)
    !mat_ready |-> $past(inv_valid && !inv_ready))
    else $error("request side stalled without output stall");

endmodule

bind matrix_inverse_3x3_core mi3_chk u_mi3_chk (
  .clk         (clk),
  .rst         (rst),
  .mat_ready   (mat.ready),
  .inv_valid   (inv.valid),
  .inv_ready   (inv.ready),
  .inv_payload (inv.payload)
);
`default_nettype wire

// ===== test/matrix_inverse_3x3_core_tb.sv =====
// Testbench for the 3x3 matrix inverse core: exact-arithmetic predictor and in-order check.
`timescale 1ns / 1ps
`default_nettype none
module matrix_inverse_3x3_core_tb;
  import mi3_pkg::*;

  localparam int CLK_PERIOD = 12;
  localparam int N_RANDOM   = 450;
  localparam int IDLE_LIMIT = 2000;

  logic clk;
  logic rst;

  mi3_in_if  mat ();
  mi3_out_if inv ();

  matrix_inverse_3x3_core dut (
    .clk (clk),
    .rst (rst),
    .mat (mat.sink),
    .inv (inv.source)
  );

  // exact inverse by adjugate; widths cover every intermediate
  function automatic mi3_out_t invert_matrix(mi3_in_t m);
    logic signed [31:0]  e [9];
    logic signed [65:0]  cof [9];
    logic signed [99:0]  det;
    logic [99:0]         dmag;
    logic [99:0]         cmag;
    logic [131:0]        quo;
    logic signed [31:0]  res [10];
    logic                ovf;
    logic                dneg;
    logic                cneg;
    mi3_out_t            o;
    e = '{m.a00, m.a01, m.a02, m.a10, m.a11, m.a12, m.a20, m.a21, m.a22};
    cof[0] = 66'(e[4]) * e[8] - 66'(e[5]) * e[7];
    cof[1] = 66'(e[7]) * e[2] - 66'(e[8]) * e[1];
    cof[2] = 66'(e[1]) * e[5] - 66'(e[2]) * e[4];
    cof[3] = 66'(e[5]) * e[6] - 66'(e[3]) * e[8];
    cof[4] = 66'(e[8]) * e[0] - 66'(e[6]) * e[2];
    cof[5] = 66'(e[2]) * e[3] - 66'(e[0]) * e[5];
    cof[6] = 66'(e[3]) * e[7] - 66'(e[4]) * e[6];
    cof[7] = 66'(e[6]) * e[1] - 66'(e[7]) * e[0];
    cof[8] = 66'(e[0]) * e[4] - 66'(e[1]) * e[3];
    det = 100'(e[0]) * cof[0] + 100'(e[3]) * cof[1] + 100'(e[6]) * cof[2];
    o = '0;
    if (det == 0) begin
      o.singular = 1'b1;
      return o;
    end
    ovf = 1'b0;
    dneg = det < 0;
    dmag = dneg ? -det : det;
    for (int k = 0; k < 10; k++) begin
      if (k < 9) begin
        cneg = cof[k] < 0;
        cmag = cneg ? 100'(-cof[k]) : 100'(cof[k]);
        quo = ({32'd0, cmag} << 32) / {32'd0, dmag};
        cneg = (cneg != dneg) && quo != 0;
      end else begin
        cneg = dneg;
        quo = {32'd0, dmag >> 32};
      end
      if (!cneg && quo > 132'h7fffffff) begin
        res[k] = 32'h7fffffff;
        ovf = 1'b1;
      end else if (cneg && quo > 132'h80000000) begin
        res[k] = 32'h80000000;
        ovf = 1'b1;
      end else begin
        res[k] = cneg ? -quo[31:0] : quo[31:0];
      end
    end
    o.inv00 = res[0]; o.inv01 = res[1]; o.inv02 = res[2];
    o.inv10 = res[3]; o.inv11 = res[4]; o.inv12 = res[5];
    o.inv20 = res[6]; o.inv21 = res[7]; o.inv22 = res[8];
    o.det_value = res[9];
    o.overflow = ovf;
    return o;
  endfunction

  class inverse_scoreboard;
    mi3_out_t expected_inverses[$];
    int       errors;

    function void note_request(mi3_in_t m);
      expected_inverses.push_back(invert_matrix(m));
    endfunction

    function void check_result(mi3_out_t got);
      mi3_out_t want;
      if (expected_inverses.size() == 0) begin
        $display("%0t: unexpected result %h", $time, got);
        errors++;
        return;
      end
      want = expected_inverses.pop_front();
      if (got !== want) begin
        $display("%0t: mismatch expected %h actual %h", $time, want, got);
        errors++;
      end
    endfunction
  endclass

  inverse_scoreboard board;
  int  idle_cycles;
  bit  sink_hold_off;

  initial begin
    clk = 1'b0;
    forever #(CLK_PERIOD / 2) clk = ~clk;
  end

  // accept and check on rising edges
  always @(posedge clk) begin
    if (rst) begin
      idle_cycles <= 0;
    end else begin
      if (mat.valid && mat.ready) board.note_request(mat.payload);
      if (inv.valid && inv.ready) board.check_result(inv.payload);
      if ((mat.valid && mat.ready) || (inv.valid && inv.ready))
        idle_cycles <= 0;
      else
        idle_cycles <= idle_cycles + 1;
      if (idle_cycles > IDLE_LIMIT) begin
        $display("RESULT: ERROR");
        $finish;
      end
    end
  end

  // random backpressure, with quiet stretches
  initial begin
    int stall;
    inv.ready = 1'b0;
    @(negedge clk);
    while (rst) @(negedge clk);
    forever begin
      stall = sink_hold_off ? 0 : $urandom_range(0, 6);
      inv.ready = 1'b0;
      repeat (stall) @(negedge clk);
      inv.ready = 1'b1;
      @(posedge clk);
      while (!inv.valid) @(posedge clk);
      @(negedge clk);
    end
  end

  task automatic send_matrix(mi3_in_t m, int gap);
    mat.valid = 1'b0;
    repeat (gap) @(negedge clk);
    mat.payload = m;
    mat.valid = 1'b1;
    @(posedge clk);
    while (!mat.ready) @(posedge clk);
    @(negedge clk);
    mat.valid = 1'b0;
  endtask

  function automatic logic [31:0] pick_elem();
    case ($urandom_range(0, 5))
      0: return $urandom;
      1: return 32'(signed'($urandom_range(0, 8)) - 4) <<< 16;
      2: return {$urandom_range(0, 1) ? 16'hffff : 16'h0000, 16'($urandom)};
      3: return $urandom_range(0, 1) ? 32'h80000000 : 32'h7fffffff;
      default: return 32'(signed'($urandom_range(0, 2000000)) - 1000000);
    endcase
  endfunction

  function automatic mi3_in_t random_matrix();
    mi3_in_t m;
    m = {pick_elem(), pick_elem(), pick_elem(), pick_elem(), pick_elem(),
         pick_elem(), pick_elem(), pick_elem(), pick_elem()};
    // occasionally make rows dependent to hit singular cases
    if ($urandom_range(0, 9) == 0) begin
      m.a20 = m.a00; m.a21 = m.a01; m.a22 = m.a02;
    end
    return m;
  endfunction

  function automatic mi3_in_t diag(logic [31:0] d0, logic [31:0] d1, logic [31:0] d2);
    mi3_in_t m;
    m = '0;
    m.a00 = d0; m.a11 = d1; m.a22 = d2;
    return m;
  endfunction

  initial begin
    mi3_in_t directed[$];
    board = new();
    sink_hold_off = 1'b0;
    rst = 1'b1;
    mat.valid = 1'b0;
    mat.payload = '0;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    directed.push_back(diag(32'h00010000, 32'h00010000, 32'h00010000));
    directed.push_back('0);
    directed.push_back(diag(32'h00000001, 32'h00000001, 32'h00000001));
    directed.push_back(diag(32'h7fffffff, 32'h7fffffff, 32'h7fffffff));
    directed.push_back(diag(32'h80000000, 32'h80000000, 32'h80000000));
    directed.push_back(diag(32'hffff0000, 32'h00020000, 32'h00008000));
    directed.push_back(diag(32'h80000000, 32'h7fffffff, 32'hffffffff));
    directed.push_back({9{32'hffffffff}});
    directed.push_back({9{32'h80000000}});
    directed.push_back({32'h00010000, 32'h00020000, 32'h00030000,
                        32'h00040000, 32'h00050000, 32'h00060000,
                        32'h00070000, 32'h00080000, 32'h000a0000});
    directed.push_back({32'h00010000, 32'h00020000, 32'h00030000,
                        32'h00040000, 32'h00050000, 32'h00060000,
                        32'h00070000, 32'h00080000, 32'h00090000});
    directed.push_back({32'h00000000, 32'h00010000, 32'h00000000,
                        32'h00000000, 32'h00000000, 32'h00010000,
                        32'h00010000, 32'h00000000, 32'h00000000});
    directed.push_back({32'h55555555, 32'haaaaaaaa, 32'h12345678,
                        32'hedcba987, 32'h7fffffff, 32'h80000000,
                        32'h00000001, 32'hffffffff, 32'h0f0f0f0f});
    foreach (directed[i]) send_matrix(directed[i], $urandom_range(0, 6));

    // drain completely once, with no new requests and backpressure held off
    sink_hold_off = 1'b1;
    while (board.expected_inverses.size() != 0) @(negedge clk);
    sink_hold_off = 1'b0;

    for (int n = 0; n < N_RANDOM; n++)
      send_matrix(random_matrix(), (n % 100 < 30) ? 0 : $urandom_range(0, 6));

    while (board.expected_inverses.size() != 0) @(negedge clk);
    repeat (60) @(posedge clk);
    if (board.errors == 0 && board.expected_inverses.size() == 0)
      $display("RESULT: OK");
    else
      $display("RESULT: ERROR");
    $finish;
  end
endmodule
`default_nettype wire
